[sv/sis_pkg.sv]
`default_nettype none

package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic found;
        logic at_cap;
    } sts_t;

endpackage

`default_nettype wire

[sv/sis_datapath.sv]
`default_nettype none

module sis_datapath
    import sis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl,
    input  logic signed [KEY_W-1:0] value,
    output sts_t                    sts,
    output logic [COUNT_W-1:0]      count
);

    logic signed [KEY_W-1:0] entries_reg  [CAPACITY];
    logic signed [KEY_W-1:0] entries_next [CAPACITY];
    logic signed [KEY_W-1:0] prev_entry   [CAPACITY];
    logic signed [KEY_W-1:0] next_entry   [CAPACITY];
    logic signed [KEY_W-1:0] key_reg;
    logic [CAPACITY-1:0]     lt_reg;
    logic [CAPACITY-1:0]     lt_next;
    logic [CAPACITY-1:0]     eq_reg;
    logic [CAPACITY-1:0]     eq_next;
    logic [CAPACITY-1:0]     lt_below;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;

    // every cell compares its own entry against the incoming key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_next[i] = (OCC_W'(i) < occ_reg) && (entries_reg[i] < value);
            eq_next[i] = (OCC_W'(i) < occ_reg) && (entries_reg[i] == value);
        end
    end

    // bit i: cell i-1 holds a smaller key; cell 0 has nothing below it
    assign lt_below = {lt_reg[CAPACITY-2:0], 1'b1};

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign prev_entry[g] = key_reg;
        end
        else
        begin : g_mid
            assign prev_entry[g] = entries_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign next_entry[g] = entries_reg[g];
        end
        else
        begin : g_low
            assign next_entry[g] = entries_reg[g+1];
        end

        always_comb
        begin
            entries_next[g] = entries_reg[g];
            case (ctl.op)
                OP_INSERT:
                begin
                    // the insert point takes the key, cells above shift up
                    if (!lt_reg[g])
                    begin
                        entries_next[g] = lt_below[g] ? key_reg : prev_entry[g];
                    end
                end
                OP_REMOVE:
                begin
                    if (!lt_reg[g])
                    begin
                        entries_next[g] = next_entry[g];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        case (ctl.op)
            OP_INSERT: occ_next = occ_reg + OCC_W'(1);
            OP_REMOVE: occ_next = occ_reg - OCC_W'(1);
            OP_CLEAR:  occ_next = '0;
            default:   occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
        if (ctl.capture)
        begin
            key_reg <= value;
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign sts.found  = |eq_reg;
    assign sts.at_cap = (occ_reg >= OCC_W'(CAPACITY));
    assign count      = COUNT_W'(occ_reg);

endmodule

`default_nettype wire

[sv/sis_controller.sv]
`default_nettype none

module sis_controller
    import sis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  sts_t       sts,
    output ctl_t       ctl,
    output logic       busy,
    output logic       done,
    output logic       success,
    output logic       full_res
);

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   done_reg;
    logic   done_next;
    logic   success_reg;
    logic   success_next;
    logic   full_res_reg;
    logic   full_res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        success_reg  <= success_next;
        full_res_reg <= full_res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        done_next     = 1'b0;
        success_next  = success_reg;
        full_res_next = full_res_reg;
        ctl.capture   = 1'b0;
        ctl.op        = OP_NONE;
        busy          = (state_reg == ST_UPDATE);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    cmd_next    = cmd_t'(command);
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                done_next     = 1'b1;
                full_res_next = 1'b0;
                state_next    = ST_IDLE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        success_next  = !sts.found && !sts.at_cap;
                        full_res_next = !sts.found && sts.at_cap;
                        if (!sts.found && !sts.at_cap)
                        begin
                            ctl.op = OP_INSERT;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        success_next = sts.found;
                        if (sts.found)
                        begin
                            ctl.op = OP_REMOVE;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        success_next = sts.found;
                    end
                    CMD_CLEAR:
                    begin
                        success_next = 1'b1;
                        ctl.op       = OP_CLEAR;
                    end
                    default:
                    begin
                        success_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign success  = success_reg;
    assign full_res = full_res_reg;

    // a result beat always lands in the cycle after the update cycle
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> done)
        else $error("result beat missing after update");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while still updating");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not enter update");

    assert property (@(posedge clk) disable iff (!rst_n) (done && full_res) |-> !success)
        else $error("full flag raised on a successful request");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (ctl.op != OP_NONE) |-> (state_reg == ST_UPDATE))
        else $error("table modified outside update cycle");

endmodule

`default_nettype wire

[sv/sorted_integer_set_core.sv]
// Sorted set of up to 64 distinct signed 32-bit keys, held in ascending order in a row of
// register cells. A request (insert, remove, lookup, clear) is taken when start is high and
// busy is low; every cell compares its entry to the key in that same cycle, and in the next
// cycle an insert or remove shifts the cells up or down by one to open or close a gap. The result
// beat (done with success, full_res and count) is registered out of the update cycle and appears for
// exactly one cycle: there is no way to hold it. busy is high for the one update cycle, so a new
// request can be accepted only once the compare-then-shift pass over the cell row is through.
// count is the number of entries held after the request.
`default_nettype none

module sorted_integer_set_core
    import sis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic signed [KEY_W-1:0] value,
    output logic                    done,
    output logic                    success,
    output logic                    full_res,
    output logic [COUNT_W-1:0]      count
);

    ctl_t ctl;
    sts_t sts;

    sis_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .sts      (sts),
        .ctl      (ctl),
        .busy     (busy),
        .done     (done),
        .success  (success),
        .full_res (full_res)
    );

    sis_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .value (value),
        .sts   (sts),
        .count (count)
    );

endmodule

`default_nettype wire
